FILE: rtl/core/pq4_pkg.sv
`default_nettype none

package pq4_pkg;

  localparam int unsigned LANES        = 32;
  localparam int unsigned ROW_BYTES    = 16;
  localparam int unsigned ROW_BITS     = 8 * ROW_BYTES;
  localparam int unsigned ACC_W        = 16;
  localparam int unsigned LANE_W       = 5;
  localparam int unsigned SEG_W        = 8;
  localparam int unsigned NUM_SEG_W    = 9;
  localparam int unsigned HALF_W       = 64;
  localparam int unsigned NIBBLE_W     = 4;
  localparam int unsigned MAX_SEGMENTS_DEF = 256;

  localparam logic [NUM_SEG_W-1:0] NUM_SEG_RESET = 9'd192;
  localparam logic [LANE_W-1:0]    LAST_LANE     = 5'd31;

  localparam logic MODE_TABLE = 1'b0;
  localparam logic MODE_CODE  = 1'b1;

  typedef logic [LANES-1:0][ACC_W-1:0] lane_sums_t;

  typedef struct packed {
    logic valid;
    logic close;
  } s1_stat_t;

endpackage

`default_nettype wire

FILE: rtl/core/pq4_if.sv
`default_nettype none

interface pq4_in_if
  import pq4_pkg::*;
;
  logic              valid;
  logic              ready;
  logic              mode;
  logic [SEG_W-1:0]  segment;
  logic [HALF_W-1:0] row_low;
  logic [HALF_W-1:0] row_high;

  modport source (output valid, output mode, output segment, output row_low,
                  output row_high, input ready);
  modport sink   (input valid, input mode, input segment, input row_low,
                  input row_high, output ready);
endinterface

interface pq4_out_if
  import pq4_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [LANE_W-1:0] lane;
  logic [ACC_W-1:0]  distance;
  logic              last;

  modport source (output valid, output lane, output distance, output last,
                  input ready);
  modport sink   (input valid, input lane, input distance, input last,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/core/pq4_lut_mem.sv
`default_nettype none

module pq4_lut_mem
  import pq4_pkg::*;
#(
  parameter int unsigned MaxSegments = MAX_SEGMENTS_DEF,
  localparam int unsigned AddrW = (MaxSegments > 1) ? $clog2(MaxSegments) : 1
) (
  input  wire logic                clk_i,
  input  wire logic                we_i,
  input  wire logic [AddrW-1:0]    waddr_i,
  input  wire logic [ROW_BITS-1:0] wdata_i,
  input  wire logic                re_i,
  input  wire logic [AddrW-1:0]    raddr_i,
  output      logic [ROW_BITS-1:0] rdata_o
);

  logic [ROW_BITS-1:0] mem [MaxSegments];
  logic [ROW_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/core/pq4_accum.sv
`default_nettype none

module pq4_accum
  import pq4_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                adv_i,
  input  wire logic                load_i,
  input  wire logic                close_i,
  input  wire logic [ROW_BITS-1:0] code_row_i,
  input  wire logic [ROW_BITS-1:0] lut_row_i,
  output      s1_stat_t            stat_o,
  output      logic                dump_o,
  output      lane_sums_t          sums_o
);

  s1_stat_t            stat_q;
  logic [ROW_BITS-1:0] code_q;
  lane_sums_t          acc_q;
  lane_sums_t          acc_d;
  lane_sums_t          sums;
  logic                fire;

  always_comb begin
    for (int unsigned k = 0; k < ROW_BYTES; k++) begin
      logic [NIBBLE_W-1:0] lo_nib;
      logic [NIBBLE_W-1:0] hi_nib;
      lo_nib = code_q[8*k +: NIBBLE_W];
      hi_nib = code_q[8*k+NIBBLE_W +: NIBBLE_W];
      sums[k] = acc_q[k] + {8'd0, lut_row_i[8*lo_nib +: 8]};
      sums[k+ROW_BYTES] = acc_q[k+ROW_BYTES] + {8'd0, lut_row_i[8*hi_nib +: 8]};
    end
  end

  assign fire   = stat_q.valid && adv_i;
  assign dump_o = fire && stat_q.close;
  assign sums_o = sums;
  assign stat_o = stat_q;

  always_comb begin
    acc_d = acc_q;
    if (fire) begin
      acc_d = stat_q.close ? '0 : sums;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stat_q <= '0;
      acc_q  <= '0;
    end else begin
      acc_q <= acc_d;
      if (adv_i) begin
        stat_q.valid <= load_i;
        stat_q.close <= close_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && load_i) begin
      code_q <= code_row_i;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/pq4_drain.sv
`default_nettype none

module pq4_drain
  import pq4_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       load_i,
  input  wire lane_sums_t sums_i,
  output      logic       busy_o,
  pq4_out_if.source       out_o
);

  lane_sums_t        buf_q;
  logic [LANE_W-1:0] lane_q;
  logic              busy_q;
  logic              pop;

  assign pop = busy_q && out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      lane_q <= '0;
    end else if (load_i) begin
      busy_q <= 1'b1;
      lane_q <= '0;
    end else if (pop) begin
      if (lane_q == LAST_LANE) begin
        busy_q <= 1'b0;
      end else begin
        lane_q <= lane_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      buf_q <= sums_i;
    end else if (pop) begin
      buf_q <= buf_q >> ACC_W;
    end
  end

  assign busy_o         = busy_q;
  assign out_o.valid    = busy_q;
  assign out_o.lane     = lane_q;
  assign out_o.distance = buf_q[0];
  assign out_o.last     = (lane_q == LAST_LANE);

endmodule

`default_nettype wire

FILE: rtl/core/pq4_lut_distance_accumulate.sv
// Channel  Direction  Payload
// in_i     sink       mode, segment, row_low, row_high
// out_o    source     lane, distance, last
// cfg      write      num_segments (cfg_we_i, cfg_wdata_i)
//
// One input transaction per cycle unless stalled: a table row is written to memory, a
// code row reads its table row from the one-port-read row memory and then adds.
// A closing code row hands 32 sums to the output buffer, one drained per ready cycle.
// A second closing row waits while that buffer still drains, stalling the input.
// Reset clears the accumulators, counters and busy flag; buffer data and table stay.
`default_nettype none

module pq4_lut_distance_accumulate
  import pq4_pkg::*;
#(
  parameter int unsigned MaxSegments = MAX_SEGMENTS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [NUM_SEG_W-1:0] cfg_wdata_i,
  pq4_in_if.sink                    in_i,
  pq4_out_if.source                 out_o
);

  localparam int unsigned AddrW  = (MaxSegments > 1) ? $clog2(MaxSegments) : 1;
  localparam int unsigned CountW = $clog2(MaxSegments + 1);
  localparam int unsigned LimW   = (CountW > NUM_SEG_W) ? CountW : NUM_SEG_W;
  localparam logic [LimW-1:0] MaxLim = LimW'(MaxSegments);

  logic [NUM_SEG_W-1:0] num_seg_q;
  logic [AddrW-1:0]     cnt_q;
  logic [AddrW-1:0]     cnt_d;
  logic [LimW-1:0]      num_ext;
  logic [LimW-1:0]      limit;
  logic                 close;
  logic                 in_fire;
  logic                 load_code;
  logic                 tbl_we;
  logic                 adv;
  logic                 busy;
  logic                 dump;
  s1_stat_t             s1_stat;
  lane_sums_t           sums;
  logic [ROW_BITS-1:0]  in_row;
  logic [ROW_BITS-1:0]  lut_row;

  assign in_row  = {in_i.row_high, in_i.row_low};
  assign num_ext = LimW'(num_seg_q);

  always_comb begin
    if (num_ext == '0) begin
      limit = LimW'(1);
    end else if (num_ext > MaxLim) begin
      limit = MaxLim;
    end else begin
      limit = num_ext;
    end
  end

  assign close = (LimW'(cnt_q) + LimW'(1)) >= limit;

  assign adv        = !s1_stat.valid || !s1_stat.close || !busy;
  assign in_i.ready = adv;
  assign in_fire    = in_i.valid && adv;
  assign load_code  = in_fire && (in_i.mode == MODE_CODE);
  assign tbl_we     = in_fire && (in_i.mode == MODE_TABLE)
                      && (LimW'(in_i.segment) < MaxLim);

  always_comb begin
    cnt_d = cnt_q;
    if (load_code) begin
      cnt_d = close ? '0 : cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_seg_q <= NUM_SEG_RESET;
      cnt_q     <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (cfg_we_i) begin
        num_seg_q <= cfg_wdata_i;
      end
    end
  end

  pq4_lut_mem #(
    .MaxSegments(MaxSegments)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (tbl_we),
    .waddr_i(AddrW'(in_i.segment)),
    .wdata_i(in_row),
    .re_i   (load_code),
    .raddr_i(cnt_q),
    .rdata_o(lut_row)
  );

  pq4_accum u_accum (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .load_i    (load_code),
    .close_i   (close),
    .code_row_i(in_row),
    .lut_row_i (lut_row),
    .stat_o    (s1_stat),
    .dump_o    (dump),
    .sums_o    (sums)
  );

  pq4_drain u_drain (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .load_i(dump),
    .sums_i(sums),
    .busy_o(busy),
    .out_o (out_o)
  );

endmodule

`default_nettype wire

FILE: rtl/core/pq4_checker.sv
`default_nettype none

module pq4_checker
  import pq4_pkg::*;
(
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              out_valid_i,
  input wire logic              out_ready_i,
  input wire logic [LANE_W-1:0] out_lane_i,
  input wire logic [ACC_W-1:0]  out_distance_i,
  input wire logic              out_last_i
);

  // The last flag marks exactly the final lane of a block.
  a_last_lane : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_last_i == (out_lane_i == LAST_LANE)))
    else $error("last flag does not match lane 31");

  // Within a block the lanes follow one another without a gap.
  a_lane_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !out_last_i |=>
      out_valid_i && (out_lane_i == $past(out_lane_i) + 1'b1))
    else $error("lane sequence broken");

  // A block opens at lane 0 after the previous one closed.
  a_block_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> (out_lane_i == '0))
    else $error("block does not start at lane 0");

  // A stalled result holds its payload.
  a_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(out_lane_i) && $stable(out_distance_i))
    else $error("stalled result changed");

endmodule

bind pq4_lut_distance_accumulate pq4_checker u_pq4_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_lane_i    (out_o.lane),
  .out_distance_i(out_o.distance),
  .out_last_i    (out_o.last)
);

`default_nettype wire

FILE: tb/pq4_scan_checker.sv
`timescale 1ns / 100ps

module pq4_scan_checker
  import pq4_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [NUM_SEG_W-1:0] cfg_wdata_i,
  pq4_in_if                    in_i,
  pq4_out_if                   out_i,
  output int                   mismatch_count_o,
  output int                   pending_o,
  output int                   result_count_o
);

  typedef struct packed {
    logic [LANE_W-1:0] lane;
    logic [ACC_W-1:0]  distance;
    logic              last;
  } lane_result_t;

  logic [7:0]           lut_q [MAX_SEGMENTS_DEF][ROW_BYTES];
  logic [ACC_W-1:0]     lane_sum_q [LANES];
  int unsigned          seg_pos_q;
  logic [NUM_SEG_W-1:0] seg_setting_q;
  lane_result_t         distance_q [$];
  lane_result_t         want_r;

  function automatic int unsigned segments_in_use(logic [NUM_SEG_W-1:0] v);
    if (v == '0) return 1;
    if (v > MAX_SEGMENTS_DEF) return MAX_SEGMENTS_DEF;
    return v;
  endfunction

  task automatic report_mismatch(string note);
    $display("%0t ns: %s", $time, note);
    mismatch_count_o++;
  endtask

  task automatic accumulate_row(logic mode, logic [SEG_W-1:0] seg,
                                logic [ROW_BITS-1:0] row);
    logic [7:0]   code;
    int unsigned  pos;
    lane_result_t res;
    if (mode == MODE_TABLE) begin
      for (int k = 0; k < ROW_BYTES; k++) lut_q[seg][k] = row[8*k +: 8];
      return;
    end
    pos = seg_pos_q;
    if (pos >= MAX_SEGMENTS_DEF) pos = MAX_SEGMENTS_DEF - 1;
    for (int k = 0; k < ROW_BYTES; k++) begin
      code = row[8*k +: 8];
      lane_sum_q[k]             += lut_q[pos][code[3:0]];
      lane_sum_q[k + ROW_BYTES] += lut_q[pos][code[7:4]];
    end
    if (pos + 1 < segments_in_use(seg_setting_q)) begin
      seg_pos_q = pos + 1;
    end else begin
      for (int k = 0; k < LANES; k++) begin
        res.lane     = LANE_W'(k);
        res.distance = lane_sum_q[k];
        res.last     = (k == LANES - 1);
        distance_q   = {distance_q, res};
        lane_sum_q[k] = '0;
      end
      seg_pos_q = 0;
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      for (int k = 0; k < LANES; k++) lane_sum_q[k] = '0;
      seg_pos_q     = 0;
      seg_setting_q = NUM_SEG_RESET;
      distance_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) seg_setting_q = cfg_wdata_i;
      if (out_i.valid && out_i.ready) begin
        result_count_o++;
        if (distance_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result, lane %0d distance %0d",
                                    out_i.lane, out_i.distance));
        end else begin
          want_r = distance_q.pop_front();
          if (out_i.lane !== want_r.lane)
            report_mismatch($sformatf("lane got %0d, expected %0d",
                                      out_i.lane, want_r.lane));
          if (out_i.distance !== want_r.distance)
            report_mismatch($sformatf("distance of lane %0d got %0d, expected %0d",
                                      want_r.lane, out_i.distance, want_r.distance));
          if (out_i.last !== want_r.last)
            report_mismatch($sformatf("last of lane %0d got %0b, expected %0b",
                                      want_r.lane, out_i.last, want_r.last));
        end
      end
      if (in_i.valid && in_i.ready)
        accumulate_row(in_i.mode, in_i.segment, {in_i.row_high, in_i.row_low});
      pending_o <= distance_q.size();
    end
  end

endmodule

FILE: tb/tb_pq4_lut_distance_accumulate.sv
`timescale 1ns / 100ps

module tb_pq4_lut_distance_accumulate;
  import pq4_pkg::*;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [NUM_SEG_W-1:0] cfg_wdata_i = '0;

  pq4_in_if  in_ch ();
  pq4_out_if out_ch ();

  int mismatches;
  int pending;
  int results;
  int idle_pct;
  int stall_pct;
  int hold_left;
  bit hold_go;
  bit hold_seen;
  bit row_loaded [MAX_SEGMENTS_DEF];
  int items_sent;
  int table_items;
  int code_pos;
  int seg_span;

  pq4_lut_distance_accumulate dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_ch.sink),
    .out_o       (out_ch.source)
  );

  pq4_scan_checker scan_chk (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_i             (in_ch),
    .out_i            (out_ch),
    .mismatch_count_o (mismatches),
    .pending_o        (pending),
    .result_count_o   (results)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (hold_go != hold_seen) begin
      hold_seen = hold_go;
      hold_left = 400;
    end
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left--;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic logic [HALF_W-1:0] rand_half();
    return {$urandom, $urandom};
  endfunction

  task automatic send_item(logic mode, logic [SEG_W-1:0] seg,
                           logic [HALF_W-1:0] lo, logic [HALF_W-1:0] hi);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid    <= 1'b1;
    in_ch.mode     <= mode;
    in_ch.segment  <= seg;
    in_ch.row_low  <= lo;
    in_ch.row_high <= hi;
    do @(posedge clk_i); while (!in_ch.ready);
    items_sent++;
    if (mode == MODE_TABLE) begin
      row_loaded[seg] = 1'b1;
      table_items++;
    end
  endtask

  // A code transaction is preceded by the table row it reads when that row
  // has not been loaded yet.
  task automatic send_code(logic [HALF_W-1:0] lo, logic [HALF_W-1:0] hi);
    if (!row_loaded[code_pos])
      send_item(MODE_TABLE, SEG_W'(code_pos), rand_half(), rand_half());
    send_item(MODE_CODE, SEG_W'($urandom_range(255)), lo, hi);
    code_pos = (code_pos + 1 < seg_span) ? code_pos + 1 : 0;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_segments(logic [NUM_SEG_W-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    seg_span = (v == '0) ? 1 : ((v > MAX_SEGMENTS_DEF) ? MAX_SEGMENTS_DEF : int'(v));
  endtask

  task automatic random_phase(int sender_idle, int recv_stall, int count);
    logic [NUM_SEG_W-1:0] setting;
    drain();
    idle_pct = sender_idle;
    stall_pct <= recv_stall;
    setting = ($urandom_range(4) == 0) ? NUM_SEG_W'($urandom_range(511))
                                       : NUM_SEG_W'($urandom_range(1, 6));
    set_segments(setting);
    repeat (count) begin
      if ($urandom_range(99) < 15)
        send_item(MODE_TABLE,
                  SEG_W'($urandom_range(1) ? $urandom_range(seg_span - 1)
                                           : $urandom_range(255)),
                  rand_half(), rand_half());
      else
        send_code(rand_half(), rand_half());
    end
  endtask

  initial begin
    in_ch.valid    = 1'b0;
    in_ch.mode     = MODE_TABLE;
    in_ch.segment  = '0;
    in_ch.row_low  = '0;
    in_ch.row_high = '0;
    idle_pct       = 0;
    stall_pct      = 0;
    code_pos       = 0;
    seg_span       = NUM_SEG_RESET;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    repeat (3) send_code(rand_half(), rand_half());
    drain();

    set_segments(9'd0);
    send_item(MODE_TABLE, 8'd0, 64'h7766554433221100, 64'hFFEEDDCCBBAA9988);
    send_code('0, '0);
    send_code('1, '1);
    send_code(64'h0F0F0F0F0F0F0F0F, 64'hF0F0F0F0F0F0F0F0);
    send_code(64'h0123456789ABCDEF, 64'hFEDCBA9876543210);
    send_item(MODE_TABLE, 8'd0, '1, '1);
    send_code(rand_half(), rand_half());
    send_item(MODE_TABLE, 8'd0, '0, '0);
    send_code(rand_half(), rand_half());
    send_item(MODE_TABLE, 8'd255, '1, '1);
    drain();

    set_segments(9'd257);
    repeat (5) send_code(rand_half(), rand_half());
    drain();
    set_segments(9'd3);
    repeat (4) send_code(rand_half(), rand_half());
    drain();
    set_segments(9'h1FF);
    repeat (6) send_code(rand_half(), rand_half());
    drain();

    set_segments(9'd4);
    repeat (2) send_code(rand_half(), rand_half());
    send_item(MODE_TABLE, 8'd2, rand_half(), rand_half());
    repeat (2) send_code(rand_half(), rand_half());
    drain();

    set_segments(9'd1);
    hold_go <= ~hold_go;
    repeat (6) send_code(rand_half(), rand_half());

    random_phase(0, 0, 12);
    random_phase(73, 0, 12);
    random_phase(0, 73, 12);
    random_phase(25, 25, 12);
    drain();
    repeat (20) @(posedge clk_i);

    $display("Covered %0d input transactions (%0d table rows) and %0d result transactions.",
             items_sent, table_items, results);
    $display("Segment settings 0 to 511, counts lowered inside a block, four idle mixes, long stall.");
    if (mismatches == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/pq4_pkg.sv
rtl/core/pq4_if.sv
rtl/core/pq4_lut_mem.sv
rtl/core/pq4_accum.sv
rtl/core/pq4_drain.sv
rtl/core/pq4_lut_distance_accumulate.sv
rtl/core/pq4_checker.sv
tb/pq4_scan_checker.sv
tb/tb_pq4_lut_distance_accumulate.sv
